@@ sv/event_timer_table_assert.svh @@
// Assertion macros for the event timer table.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef EVENT_TIMER_TABLE_ASSERT_SVH
`define EVENT_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define ETT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("event_timer_table: assertion failed");
`define ETT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("event_timer_table: assertion failed");
`else
`define ETT_ASSERT_NOW(lbl, ante, cons)
`define ETT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/etmr_pkg.sv @@
// Shared widths, command codes and result kinds of the event timer table.
// No dependencies.
package etmr_pkg;
    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 64;
    localparam int KIND_W = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_op OP_REG   = 2'd0;
    localparam t_op OP_UNREG = 2'd1;
    localparam t_op OP_SCHED = 2'd2;
    localparam t_op OP_TICK  = 2'd3;

    localparam t_kind KIND_REPLY = 2'd0;
    localparam t_kind KIND_FIRED = 2'd1;
    localparam t_kind KIND_DONE  = 2'd2;
endpackage

@@ sv/etmr_cmd_if.sv @@
// Command channel of the event timer table: valid/ready plus command fields.
// Depends on etmr_pkg.
interface etmr_cmd_if;
    import etmr_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] time_value;

    modport source (output valid, output op, output slot, output time_value, input ready);
    modport sink   (input valid, input op, input slot, input time_value, output ready);
endinterface

@@ sv/etmr_res_if.sv @@
// Result channel of the event timer table: valid/ready plus result fields.
// Depends on etmr_pkg.
interface etmr_res_if;
    import etmr_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              ok;
    logic [SLOT_W-1:0] fired_slot;
    logic [TIME_W-1:0] fired_time;
    logic              last;

    modport source (output valid, output kind, output ok, output fired_slot,
                    output fired_time, output last, input ready);
    modport sink   (input valid, input kind, input ok, input fired_slot,
                    input fired_time, input last, output ready);
endinterface

@@ sv/event_timer_table.sv @@
// Event timer table top level: command sequencer, slot flags, output register.
// Depends on etmr_pkg, etmr_cmd_if, etmr_res_if, etmr_ram, event_timer_table_assert.svh.
//
//  channel  | dir | fields                                   | results
//  ---------+-----+------------------------------------------+-------------------------
//  i_cmd    | in  | op, slot, time_value                     | -
//  o_res    | out | kind, ok, fired_slot, fired_time, last   | 1 per command, 1..17 per tick
//
// Register and schedule pass through accept, execute and reply.
// Unregister compacts the order list one entry at a time through the order RAM port, then
// replies. A tick walks the list: each list entry needs an order RAM read, a due-time RAM
// read and one shared 64-bit compare.
// Reset clears flags and list length at once; no clearing pass. A stalled result holds the
// sequencer in place; a new command is taken only when the sequencer is idle.
module event_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    etmr_cmd_if.sink      i_cmd,
    etmr_res_if.source    o_res
);
    import etmr_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_REPLY = 3'd2;
    localparam logic [2:0] S_TA    = 3'd3;
    localparam logic [2:0] S_TB    = 3'd4;
    localparam logic [2:0] S_TC    = 3'd5;
    localparam logic [2:0] S_UA    = 3'd6;
    localparam logic [2:0] S_UB    = 3'd7;

    logic [2:0]        r_state, n_state;
    t_op               r_op, n_op;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TIME_W-1:0] r_time, n_time;
    logic              r_ok, n_ok;
    logic [SLOTS-1:0]  r_reg, n_reg;
    logic [SLOTS-1:0]  r_armed, n_armed;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_i, n_i;
    logic [LW-1:0]     r_j, n_j;

    logic              r_ov, n_ov;
    t_kind             r_o_kind, n_o_kind;
    logic              r_o_ok, n_o_ok;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic [TIME_W-1:0] r_o_time, n_o_time;
    logic              r_o_last, n_o_last;

    logic              ord_we;
    logic [SW-1:0]     ord_waddr;
    logic [SW-1:0]     ord_wdata;
    logic [SW-1:0]     ord_rdata;
    logic              due_we;
    logic [TIME_W-1:0] due_rdata;

    logic [SW+SLOT_W-1:0] slot_ext;
    logic [SW-1:0]        idx;
    logic                 slot_ok;
    logic [SW+SLOT_W-1:0] fired_ext;
    logic                 out_free;
    logic                 hit;

    assign slot_ext  = {{SW{1'b0}}, r_slot};
    assign idx       = slot_ext[SW-1:0];
    assign slot_ok   = ({{LW{1'b0}}, r_slot} < (LW + SLOT_W)'(SLOTS));
    assign fired_ext = {{SLOT_W{1'b0}}, ord_rdata};
    assign out_free  = !r_ov || o_res.ready;
    // shared compare: armed flag and due time of the list entry under the walker
    assign hit       = r_armed[ord_rdata] && (due_rdata == r_time);

    etmr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (r_i[SW-1:0]),
        .o_rdata (ord_rdata)
    );

    etmr_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_due (
        .i_clk   (i_clk),
        .i_we    (due_we),
        .i_waddr (idx),
        .i_wdata (r_time),
        .i_raddr (ord_rdata),
        .o_rdata (due_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_slot   = r_slot;
        n_time   = r_time;
        n_ok     = r_ok;
        n_reg    = r_reg;
        n_armed  = r_armed;
        n_len    = r_len;
        n_i      = r_i;
        n_j      = r_j;
        n_ov     = r_ov && !o_res.ready;
        n_o_kind = r_o_kind;
        n_o_ok   = r_o_ok;
        n_o_slot = r_o_slot;
        n_o_time = r_o_time;
        n_o_last = r_o_last;
        ord_we    = 1'b0;
        ord_waddr = r_len[SW-1:0];
        ord_wdata = idx;
        due_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op    = i_cmd.op;
                    n_slot  = i_cmd.slot;
                    n_time  = i_cmd.time_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ok    = 1'b0;
                n_state = S_REPLY;
                case (r_op)
                    OP_REG: begin
                        if (slot_ok && !r_reg[idx] && (r_len < LW'(SLOTS))) begin
                            // append to the end of the order list
                            ord_we       = 1'b1;
                            n_len        = r_len + LW'(1);
                            n_reg[idx]   = 1'b1;
                            n_armed[idx] = 1'b0;
                            n_ok         = 1'b1;
                        end
                    end
                    OP_UNREG: begin
                        if (slot_ok && r_reg[idx]) begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = S_UA;
                        end
                    end
                    OP_SCHED: begin
                        if (slot_ok && r_reg[idx]) begin
                            due_we       = 1'b1;
                            n_armed[idx] = 1'b1;
                            n_ok         = 1'b1;
                        end
                    end
                    default: begin
                        n_i     = '0;
                        n_state = S_TA;
                    end
                endcase
            end
            S_REPLY: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_kind = KIND_REPLY;
                    n_o_ok   = r_ok;
                    n_o_slot = r_slot;
                    n_o_time = '0;
                    n_o_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_TA: begin
                if (r_i == r_len) begin
                    if (out_free) begin
                        n_ov     = 1'b1;
                        n_o_kind = KIND_DONE;
                        n_o_ok   = 1'b1;
                        n_o_slot = '0;
                        n_o_time = '0;
                        n_o_last = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_TB;
                end
            end
            S_TB: begin
                n_state = S_TC;
            end
            S_TC: begin
                if (hit) begin
                    // hold the entry until the result register frees up
                    if (out_free) begin
                        n_ov               = 1'b1;
                        n_o_kind           = KIND_FIRED;
                        n_o_ok             = 1'b1;
                        n_o_slot           = fired_ext[SLOT_W-1:0];
                        n_o_time           = due_rdata;
                        n_o_last           = 1'b0;
                        n_armed[ord_rdata] = 1'b0;
                        n_i                = r_i + LW'(1);
                        n_state            = S_TA;
                    end
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = S_TA;
                end
            end
            S_UA: begin
                if (r_i == r_len) begin
                    n_len      = r_j;
                    n_reg[idx] = 1'b0;
                    n_ok       = 1'b1;
                    n_state    = S_REPLY;
                end else begin
                    n_state = S_UB;
                end
            end
            S_UB: begin
                // close the gap: copy every other entry down to the write index
                if (ord_rdata != idx) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_j[SW-1:0];
                    ord_wdata = ord_rdata;
                    n_j       = r_j + LW'(1);
                end
                n_i     = r_i + LW'(1);
                n_state = S_UA;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_reg   <= '0;
            r_armed <= '0;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reg   <= n_reg;
            r_armed <= n_armed;
            r_len   <= n_len;
            r_ov    <= n_ov;
        end
        r_op     <= n_op;
        r_slot   <= n_slot;
        r_time   <= n_time;
        r_ok     <= n_ok;
        r_i      <= n_i;
        r_j      <= n_j;
        r_o_kind <= n_o_kind;
        r_o_ok   <= n_o_ok;
        r_o_slot <= n_o_slot;
        r_o_time <= n_o_time;
        r_o_last <= n_o_last;
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.kind       = r_o_kind;
    assign o_res.ok         = r_o_ok;
    assign o_res.fired_slot = r_o_slot;
    assign o_res.fired_time = r_o_time;
    assign o_res.last       = r_o_last;

`include "event_timer_table_assert.svh"

    `ETT_ASSERT_NOW(a_len_matches_flags, 1'b1, $countones(r_reg) == r_len)
    `ETT_ASSERT_NEXT(a_accept_starts_exec, i_cmd.valid && i_cmd.ready, r_state == S_EXEC)
    `ETT_ASSERT_NEXT(a_hit_fires, (r_state == S_TC) && hit && out_free,
                     o_res.valid && (o_res.kind == KIND_FIRED) && !o_res.last)
endmodule

@@ sv/etmr_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module etmr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ bench/tb_event_timer_table.sv @@
`timescale 1ns / 100ps
// Self-checking bench for event_timer_table: directed and random commands and ticks.
// Depends on etmr_pkg, etmr_cmd_if, etmr_res_if and the event_timer_table RTL.
module tb_event_timer_table;
    import etmr_pkg::*;

    localparam int NSLOT      = 16;
    localparam int RAND_CMDS  = 105;
    localparam int STALL_CAP  = 3000;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] tv;
    } t_timer_cmd;

    typedef struct packed {
        t_kind             kind;
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] tv;
        logic              last;
    } t_timer_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    etmr_cmd_if cmd_ch ();
    etmr_res_if res_ch ();

    event_timer_table #(.SLOTS(NSLOT)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    t_timer_cmd cmd_backlog[$];
    t_timer_out timer_out_q[$];

    // Timer table image kept by the bench
    bit                slot_reg[NSLOT];
    bit                slot_armed[NSLOT];
    logic [TIME_W-1:0] slot_due[NSLOT];
    int                walk_order[$];

    int  fail_count = 0;
    int  cmds_taken = 0;
    int  cmds_total = 0;
    int  stall_cycles = 0;
    bit  steady;

    // Idling is switched off for a stretch in the middle of the run
    assign steady = (cmds_taken >= 60) && (cmds_taken < 95);

    task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                   logic [TIME_W-1:0] want);
        $display("ERROR t=%0t %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic queue_out(t_kind kind, logic ok, logic [SLOT_W-1:0] slot,
                             logic [TIME_W-1:0] tv, logic last);
        t_timer_out r;
        r.kind = kind;
        r.ok   = ok;
        r.slot = slot;
        r.tv   = tv;
        r.last = last;
        timer_out_q.push_back(r);
    endtask

    // Advance the table image by one command and queue what it must produce
    task automatic apply_timer_cmd(t_timer_cmd c);
        int  s;
        logic ok;
        s  = c.slot;
        ok = 1'b0;
        if (c.op == OP_TICK) begin
            foreach (walk_order[i]) begin
                if (slot_armed[walk_order[i]] && slot_due[walk_order[i]] == c.tv) begin
                    slot_armed[walk_order[i]] = 1'b0;
                    queue_out(KIND_FIRED, 1'b1, walk_order[i][SLOT_W-1:0],
                              slot_due[walk_order[i]], 1'b0);
                end
            end
            queue_out(KIND_DONE, 1'b1, '0, '0, 1'b1);
        end else begin
            if (s < NSLOT) begin
                case (c.op)
                    OP_REG: begin
                        if (!slot_reg[s] && walk_order.size() < NSLOT) begin
                            walk_order.push_back(s);
                            slot_reg[s]   = 1'b1;
                            slot_armed[s] = 1'b0;
                            slot_due[s]   = '0;
                            ok = 1'b1;
                        end
                    end
                    OP_UNREG: begin
                        if (slot_reg[s]) begin
                            foreach (walk_order[i]) begin
                                if (walk_order[i] == s) begin
                                    walk_order.delete(i);
                                    break;
                                end
                            end
                            slot_reg[s] = 1'b0;
                            ok = 1'b1;
                        end
                    end
                    default: begin
                        if (slot_reg[s]) begin
                            slot_armed[s] = 1'b1;
                            slot_due[s]   = c.tv;
                            ok = 1'b1;
                        end
                    end
                endcase
            end
            queue_out(KIND_REPLY, ok, c.slot, '0, 1'b1);
        end
    endtask

    // Driver: hold the current transaction until taken, then load the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_backlog.size() > 0 && (steady || $urandom_range(99) >= 6)) begin
                t_timer_cmd c;
                c = cmd_backlog.pop_front();
                cmd_ch.valid      <= 1'b1;
                cmd_ch.op         <= c.op;
                cmd_ch.slot       <= c.slot;
                cmd_ch.time_value <= c.tv;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= steady || ($urandom_range(99) >= 6);
    end

    // Predict on every command transaction
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            t_timer_cmd c;
            c.op   = cmd_ch.op;
            c.slot = cmd_ch.slot;
            c.tv   = cmd_ch.time_value;
            apply_timer_cmd(c);
            cmds_taken <= cmds_taken + 1;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (timer_out_q.size() == 0) begin
                report_mismatch("unexpected result, kind", res_ch.kind, '0);
            end else begin
                t_timer_out w;
                w = timer_out_q.pop_front();
                if (res_ch.kind !== w.kind)
                    report_mismatch("kind", res_ch.kind, w.kind);
                if (res_ch.ok !== w.ok)
                    report_mismatch("ok", res_ch.ok, w.ok);
                if (res_ch.fired_slot !== w.slot)
                    report_mismatch("fired_slot", res_ch.fired_slot, w.slot);
                if (res_ch.fired_time !== w.tv)
                    report_mismatch("fired_time", res_ch.fired_time, w.tv);
                if (res_ch.last !== w.last)
                    report_mismatch("last", res_ch.last, w.last);
            end
        end
    end

    // Watchdog: drop the run after a long spell with no transaction on either side
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_CAP) begin
            $display("event_timer_table: mismatch");
            $finish;
        end
    end

    task automatic add_cmd(t_op op, int slot, logic [TIME_W-1:0] tv);
        t_timer_cmd c;
        c.op   = op;
        c.slot = slot[SLOT_W-1:0];
        c.tv   = tv;
        cmd_backlog.push_back(c);
        cmds_total++;
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [TIME_W-1:0] t_pool[4];
        bit                gen_reg[NSLOT];
        logic [TIME_W-1:0] t_a;
        logic [TIME_W-1:0] t_c;
        int                pick;
        int                s;

        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_TICK;
        cmd_ch.slot       = '0;
        cmd_ch.time_value = '0;
        res_ch.ready      = 1'b0;

        t_a = 64'h5555_aaaa_5555_aaaa;
        t_c = 64'h8000_0000_0000_0001;

        // Directed: empty tick, rejects, extremes of time, overwrite, shared due time,
        // unregister while armed and re-register clearing the schedule
        add_cmd(OP_TICK, 0, '0);
        add_cmd(OP_REG, 0, '0);
        add_cmd(OP_REG, 15, '1);
        add_cmd(OP_REG, 0, '0);
        add_cmd(OP_UNREG, 7, '0);
        add_cmd(OP_SCHED, 7, t_a);
        add_cmd(OP_SCHED, 0, '0);
        add_cmd(OP_SCHED, 15, '1);
        add_cmd(OP_TICK, 0, '0);
        add_cmd(OP_TICK, 9, '1);
        add_cmd(OP_TICK, 0, '1);
        add_cmd(OP_REG, 5, '0);
        add_cmd(OP_SCHED, 5, t_a);
        add_cmd(OP_SCHED, 15, t_a);
        add_cmd(OP_SCHED, 0, ~t_a);
        add_cmd(OP_SCHED, 0, t_a);
        add_cmd(OP_TICK, 0, t_a);
        add_cmd(OP_SCHED, 15, t_c);
        add_cmd(OP_UNREG, 15, '0);
        add_cmd(OP_REG, 15, '0);
        add_cmd(OP_TICK, 0, t_c);
        add_cmd(OP_TICK, 0, '0);
        add_cmd(OP_UNREG, 0, '0);
        add_cmd(OP_SCHED, 15, '0);
        add_cmd(OP_TICK, 0, '0);

        foreach (gen_reg[i])
            gen_reg[i] = 1'b0;
        gen_reg[5]  = 1'b1;
        gen_reg[15] = 1'b1;
        t_pool[0] = '0;
        t_pool[1] = '1;
        t_pool[2] = rand_time();
        t_pool[3] = rand_time();

        // Random: mostly schedules against registered slots and ticks at pool times
        for (int n = 0; n < RAND_CMDS; n++) begin
            pick = $urandom_range(99);
            s = $urandom_range(NSLOT - 1);
            if ($urandom_range(99) < 8)
                t_pool[$urandom_range(3)] = rand_time();
            if (pick < 25) begin
                for (int k = 0; k < 6 && gen_reg[s]; k++)
                    s = $urandom_range(NSLOT - 1);
                add_cmd(OP_REG, s, rand_time());
                gen_reg[s] = 1'b1;
            end else if (pick < 37) begin
                add_cmd(OP_UNREG, s, rand_time());
                gen_reg[s] = 1'b0;
            end else if (pick < 72) begin
                for (int k = 0; k < 8 && !gen_reg[s]; k++)
                    s = $urandom_range(NSLOT - 1);
                add_cmd(OP_SCHED, s,
                        ($urandom_range(99) < 75) ? t_pool[$urandom_range(3)] : rand_time());
            end else begin
                add_cmd(OP_TICK, $urandom_range(NSLOT - 1),
                        ($urandom_range(99) < 80) ? t_pool[$urandom_range(3)] : rand_time());
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken < cmds_total || timer_out_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("event_timer_table: match");
        else
            $display("event_timer_table: mismatch");
        $finish;
    end
endmodule
